// ----- src/sawbc_pkg.sv -----
// Shared constants, payload types and metadata layout of the set-associative write-back cache.
package sawbc_pkg;

    localparam int WAYS        = 16;
    localparam int WAY_BITS    = $clog2(WAYS);
    localparam int OFFSET_BITS = 6;
    localparam int INDEX_BITS  = 12;
    localparam int ADDR_BITS   = 27;
    localparam int BURST_BYTES = 8;
    localparam int BOFF_BITS   = $clog2(BURST_BYTES);
    localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
    localparam int LINE_BYTES  = 1 << OFFSET_BITS;
    localparam int LINE_W      = 8 * LINE_BYTES;
    localparam int BURST_W     = 8 * BURST_BYTES;
    localparam int BIDX_BITS   = ADDR_BITS - BOFF_BITS;
    localparam int BSEL_BITS   = OFFSET_BITS - BOFF_BITS;
    localparam int ROW_BITS    = ADDR_BITS - OFFSET_BITS;
    localparam int SETS        = 1 << INDEX_BITS;
    localparam int SLOT_BITS   = INDEX_BITS + WAY_BITS;
    localparam int DATA_BYTES  = 4;
    localparam int DATA_W      = 8 * DATA_BYTES;
    localparam int LEN_W       = 3;
    localparam int SEED_W      = 16;
    localparam int BUF_BYTES   = 2 * BURST_BYTES;
    localparam int BUF_W       = 8 * BUF_BYTES;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SEED_W-1:0] LFSR_POLY  = 16'hB400;
    localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [ADDR_BITS-1:0] address;
        logic [LEN_W-1:0]     length;
        logic [DATA_W-1:0]    write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              hit;
        logic              wrote_back;
        logic              crossed;
    } rsp_t;

    // One classified access as it waits between the front and the back.
    typedef struct packed {
        logic                 wr;
        logic [BIDX_BITS-1:0] burst;
        logic [BOFF_BITS-1:0] off;
        logic [LEN_W-1:0]     len;
        logic [BUF_W-1:0]     data;
        logic [BUF_BYTES-1:0] mask;
        logic                 crossed;
    } item_t;

    typedef struct packed {
        logic [WAYS-1:0]               valid;
        logic [WAYS-1:0]               dirty;
        logic [WAYS-1:0][TAG_BITS-1:0] tag;
    } meta_t;

    localparam int META_W = $bits(meta_t);

endpackage

// ----- src/set_assoc_writeback_cache_core.sv -----
// Top level of the 16-way set-associative write-back write-allocate cache with its memory.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | mode, address, length, write_data
//   rsp     | out       | rsp_valid/rsp_stall | read_data, hit, wrote_back, crossed
//   cfg     | in        | cfg_valid/cfg_ready | replace_seed (16 bits)
//
// A burst passes through the back end as a row read, a tag compare with line and memory reads,
// and a merge, with a write-back of a dirty victim before the merge when one is needed. A word
// is first taken from the queue and ends with the response, which waits while rsp_stall holds
// it; a word that crosses into a second burst runs the back-end steps once for each burst.
// After reset a clearing pass over all 2^21 rows zeroes the memory and the tag valid bits;
// no request word is taken meanwhile. A two-word queue lets the front accept while the back works.
module set_assoc_writeback_cache_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  sawbc_pkg::req_t              req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output sawbc_pkg::rsp_t              rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sawbc_pkg::SEED_W-1:0] cfg_data
);

    logic             q_valid;
    logic             q_pop;
    logic             clearing;
    sawbc_pkg::item_t q_item;

    sawbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    sawbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ----- src/sawbc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module sawbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/sawbc_front.sv -----
// Front end: accepts access words, splits them into burst form and queues them for the back end.
module sawbc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  sawbc_pkg::req_t       req,
    input  logic                  clearing,
    output logic                  q_valid,
    output sawbc_pkg::item_t      q_item,
    input  logic                  q_pop
);

    sawbc_pkg::item_t                 entry_reg [sawbc_pkg::QUEUE_DEPTH];
    logic                             wr_ptr_reg, wr_ptr_next;
    logic                             rd_ptr_reg, rd_ptr_next;
    logic [1:0]                       count_reg, count_next;
    sawbc_pkg::item_t                 cls;
    logic [sawbc_pkg::LEN_W-1:0]      len_sat;
    logic [sawbc_pkg::DATA_BYTES-1:0] byte_en;
    logic [sawbc_pkg::DATA_W-1:0]     data_masked;
    logic [sawbc_pkg::BOFF_BITS:0]    end_pos;
    logic                             push;

    always_comb
    begin
        len_sat = req.length;
        if (req.length > sawbc_pkg::LEN_W'(sawbc_pkg::DATA_BYTES))
        begin
            len_sat = sawbc_pkg::LEN_W'(sawbc_pkg::DATA_BYTES);
        end
        for (int i = 0; i < sawbc_pkg::DATA_BYTES; i++)
        begin
            byte_en[i] = sawbc_pkg::LEN_W'(i) < len_sat;
            data_masked[8*i +: 8] = byte_en[i] ? req.write_data[8*i +: 8] : 8'h00;
        end
        cls.wr    = req.mode == sawbc_pkg::MODE_WRITE;
        cls.burst = req.address[sawbc_pkg::ADDR_BITS-1:sawbc_pkg::BOFF_BITS];
        cls.off   = req.address[sawbc_pkg::BOFF_BITS-1:0];
        cls.len   = len_sat;
        cls.data  = sawbc_pkg::BUF_W'(data_masked) << {cls.off, 3'b000};
        cls.mask  = sawbc_pkg::BUF_BYTES'(byte_en) << cls.off;
        end_pos   = (sawbc_pkg::BOFF_BITS+1)'(cls.off) + (sawbc_pkg::BOFF_BITS+1)'(len_sat);
        cls.crossed = end_pos > (sawbc_pkg::BOFF_BITS+1)'(sawbc_pkg::BURST_BYTES);
    end

    assign req_stall = clearing || (count_reg == 2'(sawbc_pkg::QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign q_valid   = count_reg != 2'd0;
    assign q_item    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- src/sawbc_back.sv -----
// Back end: tag lookup, victim write-back, line fill and byte merge, one burst at a time.
module sawbc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  sawbc_pkg::item_t              q_item,
    output logic                          q_pop,
    output logic                          clearing,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sawbc_pkg::SEED_W-1:0]  cfg_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output sawbc_pkg::rsp_t               rsp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_META,
        S_LOOK,
        S_WB,
        S_APPLY,
        S_DONE
    } state_t;

    state_t                              state_reg;
    logic [sawbc_pkg::ROW_BITS-1:0]      clr_reg;
    sawbc_pkg::item_t                    item_reg;
    logic                                bsel_reg;
    logic                                hit_acc_reg;
    logic                                wb_acc_reg;
    logic                                fill_reg;
    logic [sawbc_pkg::WAY_BITS-1:0]      way_reg;
    sawbc_pkg::meta_t                    meta_reg;
    logic [sawbc_pkg::BUF_W-1:0]         rbuf_reg;
    logic [sawbc_pkg::SEED_W-1:0]        lfsr_reg, lfsr_next;
    logic                                rsp_valid_reg;
    sawbc_pkg::rsp_t                     rsp_reg;

    logic [sawbc_pkg::BIDX_BITS-1:0]     cur;
    logic [sawbc_pkg::ROW_BITS-1:0]      cur_row;
    logic [sawbc_pkg::INDEX_BITS-1:0]    cur_idx;
    logic [sawbc_pkg::TAG_BITS-1:0]      cur_tag;
    logic [sawbc_pkg::BSEL_BITS-1:0]     cur_bsel;

    logic [sawbc_pkg::META_W-1:0]        meta_rdata;
    logic [sawbc_pkg::META_W-1:0]        meta_wdata;
    logic [sawbc_pkg::INDEX_BITS-1:0]    meta_waddr;
    logic                                meta_we;
    logic [sawbc_pkg::LINE_W-1:0]        line_rdata;
    logic                                line_we;
    logic [sawbc_pkg::LINE_W-1:0]        back_rdata;
    logic [sawbc_pkg::LINE_W-1:0]        back_wdata;
    logic [sawbc_pkg::ROW_BITS-1:0]      back_waddr;
    logic                                back_we;

    sawbc_pkg::meta_t                    m;
    logic [sawbc_pkg::WAYS-1:0]          hitv;
    logic                                hit_any;
    logic                                full;
    logic [sawbc_pkg::WAY_BITS-1:0]      hit_way;
    logic [sawbc_pkg::WAY_BITS-1:0]      free_way;
    logic [sawbc_pkg::WAY_BITS-1:0]      rnd_way;
    logic [sawbc_pkg::WAY_BITS-1:0]      look_way;

    logic [sawbc_pkg::LINE_W-1:0]        src_line;
    logic [sawbc_pkg::LINE_W-1:0]        merged;
    logic [sawbc_pkg::BURST_W-1:0]       old_word;
    logic [sawbc_pkg::BURST_W-1:0]       new_word;
    logic [sawbc_pkg::BURST_W-1:0]       in_word;
    logic [sawbc_pkg::BURST_BYTES-1:0]   in_mask;
    sawbc_pkg::meta_t                    meta_new;

    logic [sawbc_pkg::BUF_W-1:0]         shifted;
    logic [sawbc_pkg::DATA_W-1:0]        rd_word;
    sawbc_pkg::rsp_t                     result;

    // The second burst of a crossing access wraps at the top of memory.
    assign cur      = item_reg.burst + sawbc_pkg::BIDX_BITS'(bsel_reg);
    assign cur_row  = cur[sawbc_pkg::BIDX_BITS-1 -: sawbc_pkg::ROW_BITS];
    assign cur_idx  = cur[sawbc_pkg::BSEL_BITS +: sawbc_pkg::INDEX_BITS];
    assign cur_tag  = cur[sawbc_pkg::BIDX_BITS-1 -: sawbc_pkg::TAG_BITS];
    assign cur_bsel = cur[sawbc_pkg::BSEL_BITS-1:0];

    // Lookup over the row read from the metadata store.
    always_comb
    begin
        m        = sawbc_pkg::meta_t'(meta_rdata);
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < sawbc_pkg::WAYS; w++)
        begin
            hitv[w] = m.valid[w] && (m.tag[w] == cur_tag);
        end
        for (int w = sawbc_pkg::WAYS - 1; w >= 0; w--)
        begin
            if (hitv[w])
            begin
                hit_way = sawbc_pkg::WAY_BITS'(w);
            end
            if (!m.valid[w])
            begin
                free_way = sawbc_pkg::WAY_BITS'(w);
            end
        end
        hit_any = |hitv;
        full    = &m.valid;
        rnd_way = lfsr_reg[sawbc_pkg::WAY_BITS-1:0];
        if (hit_any)
        begin
            look_way = hit_way;
        end
        else if (!full)
        begin
            look_way = free_way;
        end
        else
        begin
            look_way = rnd_way;
        end
    end

    // Merge of the burst into the hit line or the freshly fetched line.
    always_comb
    begin
        src_line = fill_reg ? back_rdata : line_rdata;
        old_word = src_line[cur_bsel*sawbc_pkg::BURST_W +: sawbc_pkg::BURST_W];
        in_word  = item_reg.data[bsel_reg*sawbc_pkg::BURST_W +: sawbc_pkg::BURST_W];
        in_mask  = item_reg.mask[bsel_reg*sawbc_pkg::BURST_BYTES +: sawbc_pkg::BURST_BYTES];
        for (int b = 0; b < sawbc_pkg::BURST_BYTES; b++)
        begin
            new_word[8*b +: 8] = in_mask[b] ? in_word[8*b +: 8] : old_word[8*b +: 8];
        end
        merged = src_line;
        if (item_reg.wr)
        begin
            merged[cur_bsel*sawbc_pkg::BURST_W +: sawbc_pkg::BURST_W] = new_word;
        end
        meta_new               = meta_reg;
        meta_new.valid[way_reg] = 1'b1;
        meta_new.tag[way_reg]   = cur_tag;
        meta_new.dirty[way_reg] = item_reg.wr || (!fill_reg && meta_reg.dirty[way_reg]);
    end

    always_comb
    begin
        shifted = rbuf_reg >> {item_reg.off, 3'b000};
        for (int i = 0; i < sawbc_pkg::DATA_BYTES; i++)
        begin
            rd_word[8*i +: 8] = (sawbc_pkg::LEN_W'(i) < item_reg.len) ? shifted[8*i +: 8] : 8'h00;
        end
        result.read_data  = item_reg.wr ? '0 : rd_word;
        result.hit        = hit_acc_reg;
        result.wrote_back = wb_acc_reg;
        result.crossed    = item_reg.crossed;
    end

    always_comb
    begin
        lfsr_next = lfsr_reg >> 1;
        if (lfsr_reg[0])
        begin
            lfsr_next = lfsr_next ^ sawbc_pkg::LFSR_POLY;
        end
    end

    // Store port control; the clearing pass zeroes the backing memory and the metadata.
    always_comb
    begin
        meta_we    = (state_reg == S_CLEAR) || (state_reg == S_APPLY);
        meta_waddr = (state_reg == S_CLEAR) ? clr_reg[sawbc_pkg::INDEX_BITS-1:0] : cur_idx;
        meta_wdata = (state_reg == S_CLEAR) ? '0 : sawbc_pkg::META_W'(meta_new);
        line_we    = state_reg == S_APPLY;
        back_we    = (state_reg == S_CLEAR) || (state_reg == S_WB);
        back_waddr = (state_reg == S_CLEAR) ? clr_reg : {meta_reg.tag[way_reg], cur_idx};
        back_wdata = (state_reg == S_CLEAR) ? '0 : line_rdata;
    end

    sawbc_ram #(
        .WIDTH (sawbc_pkg::META_W),
        .DEPTH (sawbc_pkg::SETS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (cur_idx),
        .rdata (meta_rdata)
    );

    sawbc_ram #(
        .WIDTH (sawbc_pkg::LINE_W),
        .DEPTH (sawbc_pkg::SETS * sawbc_pkg::WAYS)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr ({cur_idx, way_reg}),
        .wdata (merged),
        .raddr ({cur_idx, look_way}),
        .rdata (line_rdata)
    );

    sawbc_ram #(
        .WIDTH (sawbc_pkg::LINE_W),
        .DEPTH (1 << sawbc_pkg::ROW_BITS)
    ) u_back_ram (
        .clk   (clk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .raddr (cur_row),
        .rdata (back_rdata)
    );

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign clearing  = state_reg == S_CLEAR;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            bsel_reg      <= 1'b0;
            hit_acc_reg   <= 1'b1;
            wb_acc_reg    <= 1'b0;
            fill_reg      <= 1'b0;
            way_reg       <= '0;
            lfsr_reg      <= sawbc_pkg::SEED_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        bsel_reg    <= 1'b0;
                        hit_acc_reg <= 1'b1;
                        wb_acc_reg  <= 1'b0;
                        state_reg   <= S_META;
                    end
                end
                S_META:
                begin
                    state_reg <= S_LOOK;
                end
                S_LOOK:
                begin
                    way_reg  <= look_way;
                    fill_reg <= !hit_any;
                    if (!hit_any)
                    begin
                        hit_acc_reg <= 1'b0;
                    end
                    if (!hit_any && full && m.dirty[rnd_way])
                    begin
                        state_reg <= S_WB;
                    end
                    else
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_WB:
                begin
                    wb_acc_reg <= 1'b1;
                    state_reg  <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (!bsel_reg && item_reg.crossed)
                    begin
                        bsel_reg  <= 1'b1;
                        state_reg <= S_META;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if ((state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            // A seed write reloads the generator at once.
            if (cfg_valid)
            begin
                lfsr_reg <= cfg_data;
            end
            else if ((state_reg == S_LOOK) && !hit_any && full)
            begin
                lfsr_reg <= lfsr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
            rbuf_reg <= '0;
        end
        if (state_reg == S_LOOK)
        begin
            meta_reg <= m;
        end
        if (state_reg == S_APPLY)
        begin
            rbuf_reg[bsel_reg*sawbc_pkg::BURST_W +: sawbc_pkg::BURST_W] <= old_word;
        end
        if ((state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_reg <= result;
        end
    end

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside the completion step");

    a_victim_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WB |-> meta_reg.valid[way_reg] && meta_reg.dirty[way_reg])
        else $error("write-back of a clean or invalid way");

    a_seed_load: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> lfsr_reg == $past(cfg_data))
        else $error("seed write did not load the generator");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !rsp_valid_reg && !q_pop)
        else $error("traffic during the clearing pass");

endmodule

// ----- bench/set_assoc_writeback_cache_core_tb.sv -----
// Self-checking testbench of the set-associative write-back cache core with a built-in cache predictor.
`timescale 1ns / 1ps

module set_assoc_writeback_cache_core_tb;

    localparam int IDLE_LIMIT = 8000000;
    localparam int SETTLE     = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    sawbc_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    sawbc_pkg::rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [sawbc_pkg::SEED_W-1:0] cfg_data = '0;

    set_assoc_writeback_cache_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Predicted cache state.
    bit                             way_valid [sawbc_pkg::SETS*sawbc_pkg::WAYS];
    bit                             way_dirty [sawbc_pkg::SETS*sawbc_pkg::WAYS];
    logic [sawbc_pkg::TAG_BITS-1:0] way_tag   [sawbc_pkg::SETS*sawbc_pkg::WAYS];
    logic [sawbc_pkg::LINE_W-1:0]   line_data [int];
    logic [7:0]                     mem_bytes [int];
    logic [sawbc_pkg::SEED_W-1:0]   victim_lfsr = sawbc_pkg::SEED_RESET;

    // Byte lanes of the access spread over two bursts.
    logic [7:0] lane_data [sawbc_pkg::BUF_BYTES];
    bit         lane_mask [sawbc_pkg::BUF_BYTES];
    bit         all_hit;
    bit         any_writeback;

    sawbc_pkg::req_t pending_access [$];
    sawbc_pkg::rsp_t expected_rsp [$];
    int   err_count = 0;
    int   idle_cycles = 0;
    bit   hold_sender = 1'b0;

    // Per-phase address pool: two neighbouring sets and a modest set of 28 tags.
    logic [sawbc_pkg::INDEX_BITS-1:0] pool_set;
    logic [sawbc_pkg::TAG_BITS-1:0]   pool_tag;

    function automatic logic [7:0] mem_read(logic [sawbc_pkg::ADDR_BITS-1:0] a);
        return mem_bytes.exists(int'(a)) ? mem_bytes[int'(a)] : 8'h00;
    endfunction

    function automatic void touch_burst(logic [sawbc_pkg::ADDR_BITS-1:0] baddr, bit wr,
                                        int half);
        logic [sawbc_pkg::INDEX_BITS-1:0] idx;
        logic [sawbc_pkg::TAG_BITS-1:0]   tg;
        logic [sawbc_pkg::ADDR_BITS-1:0]  vaddr;
        logic [sawbc_pkg::ADDR_BITS-1:0]  laddr;
        logic [sawbc_pkg::LINE_W-1:0]     ln;
        int way, slot, base, p;
        idx  = baddr[sawbc_pkg::OFFSET_BITS +: sawbc_pkg::INDEX_BITS];
        tg   = baddr[sawbc_pkg::ADDR_BITS-1 -: sawbc_pkg::TAG_BITS];
        base = int'(idx) * sawbc_pkg::WAYS;
        way  = -1;
        for (int w = 0; w < sawbc_pkg::WAYS; w++)
            if (way < 0 && way_valid[base+w] && way_tag[base+w] == tg)
                way = w;
        if (way < 0)
        begin
            all_hit = 1'b0;
            for (int w = 0; w < sawbc_pkg::WAYS; w++)
                if (way < 0 && !way_valid[base+w])
                    way = w;
            if (way < 0)
            begin
                way = int'(victim_lfsr[sawbc_pkg::WAY_BITS-1:0]);
                victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ sawbc_pkg::LFSR_POLY)
                                             : (victim_lfsr >> 1);
                slot = base + way;
                if (way_dirty[slot])
                begin
                    vaddr = {way_tag[slot], idx, {sawbc_pkg::OFFSET_BITS{1'b0}}};
                    for (int i = 0; i < sawbc_pkg::LINE_BYTES; i++)
                        mem_bytes[int'(vaddr) + i] = line_data[slot][8*i +: 8];
                    any_writeback = 1'b1;
                end
            end
            slot  = base + way;
            laddr = {baddr[sawbc_pkg::ADDR_BITS-1:sawbc_pkg::OFFSET_BITS],
                     {sawbc_pkg::OFFSET_BITS{1'b0}}};
            for (int i = 0; i < sawbc_pkg::LINE_BYTES; i++)
                ln[8*i +: 8] = mem_read(sawbc_pkg::ADDR_BITS'(laddr + i));
            line_data[slot] = ln;
            way_valid[slot] = 1'b1;
            way_dirty[slot] = 1'b0;
            way_tag[slot]   = tg;
        end
        slot = base + way;
        ln = line_data[slot];
        for (int i = 0; i < sawbc_pkg::BURST_BYTES; i++)
        begin
            p = (int'(baddr[sawbc_pkg::OFFSET_BITS-1:0]) + i) % sawbc_pkg::LINE_BYTES;
            if (wr)
            begin
                if (lane_mask[half+i])
                    ln[8*p +: 8] = lane_data[half+i];
            end
            else
            begin
                lane_data[half+i] = ln[8*p +: 8];
            end
        end
        line_data[slot] = ln;
        if (wr)
            way_dirty[slot] = 1'b1;
    endfunction

    function automatic sawbc_pkg::rsp_t cache_access(sawbc_pkg::req_t r);
        sawbc_pkg::rsp_t res;
        bit wr;
        int len, off;
        logic [sawbc_pkg::ADDR_BITS-1:0] b0;
        wr  = (r.mode == sawbc_pkg::MODE_WRITE);
        len = (r.length > 4) ? 4 : int'(r.length);
        off = int'(r.address[sawbc_pkg::BOFF_BITS-1:0]);
        for (int i = 0; i < sawbc_pkg::BUF_BYTES; i++)
        begin
            lane_data[i] = 8'h00;
            lane_mask[i] = 1'b0;
        end
        for (int i = 0; i < len; i++)
        begin
            lane_data[off+i] = r.write_data[8*i +: 8];
            lane_mask[off+i] = 1'b1;
        end
        all_hit = 1'b1;
        any_writeback = 1'b0;
        b0 = sawbc_pkg::ADDR_BITS'(r.address - off);
        touch_burst(b0, wr, 0);
        res.crossed = (off + len > sawbc_pkg::BURST_BYTES);
        if (res.crossed)
            touch_burst(sawbc_pkg::ADDR_BITS'(b0 + sawbc_pkg::BURST_BYTES), wr,
                        sawbc_pkg::BURST_BYTES);
        res.read_data = '0;
        if (!wr)
            for (int i = 0; i < len; i++)
                res.read_data[8*i +: 8] = lane_data[off+i];
        res.hit = all_hit;
        res.wrote_back = any_writeback;
        return res;
    endfunction

    function automatic sawbc_pkg::req_t make_access(logic m,
                                                    logic [sawbc_pkg::ADDR_BITS-1:0] a,
                                                    int len,
                                                    logic [sawbc_pkg::DATA_W-1:0] d);
        sawbc_pkg::req_t r;
        r.mode = m;
        r.address = a;
        r.length = len[sawbc_pkg::LEN_W-1:0];
        r.write_data = d;
        return r;
    endfunction

    function automatic sawbc_pkg::req_t random_access();
        logic [sawbc_pkg::ADDR_BITS-1:0] a;
        logic [sawbc_pkg::OFFSET_BITS-1:0] off;
        int len;
        if ($urandom_range(0, 9) < 7)
        begin
            // Crowd a couple of sets with more tags than ways to force evictions.
            off = sawbc_pkg::OFFSET_BITS'(($urandom_range(0, 2) == 0)
                ? $urandom_range(sawbc_pkg::LINE_BYTES - 4, sawbc_pkg::LINE_BYTES - 1)
                : $urandom);
            a = {pool_tag + sawbc_pkg::TAG_BITS'($urandom_range(0, 27)),
                 pool_set + sawbc_pkg::INDEX_BITS'($urandom_range(0, 1)), off};
        end
        else
        begin
            a = sawbc_pkg::ADDR_BITS'($urandom);
        end
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = $urandom_range(5, 7);
            default: len = $urandom_range(1, 4);
        endcase
        return make_access(1'($urandom_range(0, 1)), a, len, $urandom);
    endfunction

    task automatic write_seed(logic [sawbc_pkg::SEED_W-1:0] seed);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        victim_lfsr = seed;
    endtask

    task automatic drain();
        while (pending_access.size() > 0 || req_valid || expected_rsp.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Sender: bursts of words separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n && (!req_valid || !req_stall))
        begin
            if (req_valid)
                expected_rsp.push_back(cache_access(req));
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_access.size() > 0 && !hold_sender)
            begin
                req <= pending_access.pop_front();
                req_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each taken word and switches among three stall densities.
    int stall_mode = 0;
    int cyc = 0;
    always @(posedge clk)
    begin
        sawbc_pkg::rsp_t exp_w;
        if (rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected word: read_data %h", rsp.read_data);
                err_count++;
            end
            else
            begin
                exp_w = expected_rsp.pop_front();
                if (rsp.read_data !== exp_w.read_data)
                begin
                    $error("read_data: expected %h, got %h", exp_w.read_data, rsp.read_data);
                    err_count++;
                end
                if (rsp.hit !== exp_w.hit)
                begin
                    $error("hit: expected %b, got %b", exp_w.hit, rsp.hit);
                    err_count++;
                end
                if (rsp.wrote_back !== exp_w.wrote_back)
                begin
                    $error("wrote_back: expected %b, got %b", exp_w.wrote_back, rsp.wrote_back);
                    err_count++;
                end
                if (rsp.crossed !== exp_w.crossed)
                begin
                    $error("crossed: expected %b, got %b", exp_w.crossed, rsp.crossed);
                    err_count++;
                end
            end
        end
        cyc++;
        if (cyc % 64 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Watchdog: allows for the clearing pass after reset.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("set_assoc_writeback_cache_core_tb: errors");
            $finish;
        end
    end

    logic [sawbc_pkg::SEED_W-1:0] seeds [5];

    initial
    begin
        seeds[0] = 16'd1;
        seeds[1] = 16'hFFFF;
        seeds[2] = 16'd0;
        seeds[3] = 16'($urandom_range(1, 65535));
        seeds[4] = sawbc_pkg::SEED_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_seed(seeds[ph]);
            pool_set = sawbc_pkg::INDEX_BITS'($urandom);
            pool_tag = sawbc_pkg::TAG_BITS'($urandom);
            if (ph == 0)
            begin
                pending_access.push_back(make_access(sawbc_pkg::MODE_READ, 27'h0, 4, 32'h0));
                pending_access.push_back(make_access(sawbc_pkg::MODE_WRITE, 27'h7FFFFFE, 4,
                                                     32'hFFFFFFFF));
                pending_access.push_back(make_access(sawbc_pkg::MODE_READ, 27'h7FFFFFE, 4,
                                                     32'hFFFFFFFF));
                pending_access.push_back(make_access(sawbc_pkg::MODE_READ, 27'h0, 2, 32'h0));
                pending_access.push_back(make_access(sawbc_pkg::MODE_WRITE, 27'h100, 0,
                                                     32'hA5A5A5A5));
                pending_access.push_back(make_access(sawbc_pkg::MODE_READ, 27'h100, 0,
                                                     32'hFFFFFFFF));
                pending_access.push_back(make_access(sawbc_pkg::MODE_WRITE, 27'h7, 7,
                                                     32'h12345678));
                pending_access.push_back(make_access(sawbc_pkg::MODE_READ, 27'h5, 5, 32'h0));
                pending_access.push_back(make_access(sawbc_pkg::MODE_WRITE, 27'h3F, 2,
                                                     32'hCAFEBEEF));
                pending_access.push_back(make_access(sawbc_pkg::MODE_READ, 27'h3E, 4, 32'h0));
                pending_access.push_back(make_access(sawbc_pkg::MODE_WRITE, 27'h4001, 1,
                                                     32'h000000FF));
                pending_access.push_back(make_access(sawbc_pkg::MODE_READ, 27'h4000, 3, 32'h0));
                // Same set, many tags: fills all ways, then evicts a dirty line.
                for (int t = 0; t < 18; t++)
                    pending_access.push_back(make_access(sawbc_pkg::MODE_WRITE,
                                                         {9'(t), 12'h5, 6'h4}, 4, $urandom));
                pending_access.push_back(make_access(sawbc_pkg::MODE_READ,
                                                     {9'd0, 12'h5, 6'h4}, 4, 32'h0));
            end
            for (int n = 0; n < 80; n++)
                pending_access.push_back(random_access());
            drain();
        end
        if (err_count == 0)
            $display("set_assoc_writeback_cache_core_tb: clean");
        else
            $display("set_assoc_writeback_cache_core_tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
src/sawbc_pkg.sv
src/sawbc_ram.sv
src/sawbc_front.sv
src/sawbc_back.sv
src/set_assoc_writeback_cache_core.sv
bench/set_assoc_writeback_cache_core_tb.sv
